### sv/tsa_pkg.sv
// Types and constants shared by the timed slot allocator modules.
// Holds the transfer payload structs, the slot record and the head control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsa_pkg;

    localparam logic       FUNC_PASS         = 1'b0;
    localparam logic       FUNC_ADD          = 1'b1;
    localparam logic [7:0] OWNER_PLACEHOLDER = 8'd42;
    localparam logic [31:0] TIME_MAX         = 32'hFFFF_FFFF;
    localparam logic [6:0] POOL_RESET        = 7'd64;

    typedef struct packed {
        logic        func;
        logic [7:0]  proc_name;
        logic [6:0]  request_size;
        logic [15:0] amount;
    } t_in;

    typedef struct packed {
        logic       accepted;
        logic [6:0] freed_count;
        logic [6:0] free_count;
    } t_out;

    typedef struct packed {
        logic        busy;
        logic [7:0]  owner;
        logic [31:0] expiry;
    } t_slot;

    // Controls for the processing point at the head of the ring.
    typedef struct packed {
        logic        active;   // an item is walking the ring
        logic        func;
        logic        grant;    // the add request fits
        logic        in_pool;  // the slot at the head lies inside the pool
        logic        want;     // slots are still to be taken
        logic [7:0]  name;
        logic [31:0] tgt;      // new time for a pass, expiry for an add
    } t_head_ctl;

endpackage

`default_nettype wire

### sv/tsa_cell.sv
// One slot cell of the ring: holds a slot record and loads its neighbor's on a shift.
// Depends on tsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsa_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_clear,
    input  wire logic           i_shift,
    input  wire tsa_pkg::t_slot i_slot,
    output tsa_pkg::t_slot      o_slot
);

    tsa_pkg::t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_slot.busy   <= 1'b0;
            r_slot.owner  <= tsa_pkg::OWNER_PLACEHOLDER;
            r_slot.expiry <= '0;
        end else if (i_shift) begin
            r_slot <= i_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

`default_nettype wire

### sv/tsa_head.sv
// Processing point of the ring: expires or allocates the slot passing the head.
// Depends on tsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsa_head (
    input  wire tsa_pkg::t_slot     i_slot,
    input  wire tsa_pkg::t_head_ctl i_ctl,
    output tsa_pkg::t_slot          o_slot,
    output logic                    o_freed,
    output logic                    o_taken
);

    always_comb begin
        o_slot  = i_slot;
        o_freed = 1'b0;
        o_taken = 1'b0;
        if (i_ctl.active && i_ctl.in_pool) begin
            if (i_ctl.func == tsa_pkg::FUNC_PASS) begin
                if (i_slot.busy && (i_slot.expiry <= i_ctl.tgt)) begin
                    o_slot.busy  = 1'b0;
                    o_slot.owner = tsa_pkg::OWNER_PLACEHOLDER;
                    o_freed      = 1'b1;
                end
            end else if (i_ctl.grant && i_ctl.want && !i_slot.busy) begin
                o_slot.busy   = 1'b1;
                o_slot.owner  = i_ctl.name;
                o_slot.expiry = i_ctl.tgt;
                o_taken       = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### sv/timed_slot_allocator_unit.sv
// Timed slot allocator: a ring of SLOTS slot cells rotated once per item past one head unit.
// Busy is high for the whole rotation and a start is taken only while the unit is idle,
// so a new item is not accepted before the result of the last one is registered.
// The result is shown for one cycle and the receiver cannot stall it.
// Reset (synchronous, active low) and any pool_size write clear all slots.
// Depends on tsa_pkg, tsa_cell and tsa_head.
`timescale 1ns / 1ps
`default_nettype none

module timed_slot_allocator_unit #(
    parameter int SLOTS = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [6:0]    i_cfg_data,
    input  wire logic          start,
    input  wire tsa_pkg::t_in  i_item,
    output logic               busy,
    output logic               o_strobe,
    output tsa_pkg::t_out      o_result
);

    localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW  = (IW > 7) ? IW : 7;
    localparam int CAP = (SLOTS < 127) ? SLOTS : 127;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [6:0]    r_pool;
    logic [6:0]    r_free, n_free;
    logic [6:0]    r_freed, n_freed;
    logic [6:0]    r_left, n_left;
    logic [31:0]   r_now;
    logic [31:0]   r_tgt;
    logic [7:0]    r_name;
    logic          r_func;
    logic          r_grant;
    logic [IW-1:0] r_idx;

    logic          accept;
    logic          last;
    logic [32:0]   time_sum;
    logic [31:0]   time_sat;
    logic          freed;
    logic          taken;

    tsa_pkg::t_slot     cell_q [SLOTS];
    tsa_pkg::t_slot     head_next;
    tsa_pkg::t_head_ctl head_ctl;

    function automatic logic [6:0] pool_limit(input logic [6:0] p);
        return (p > 7'(CAP)) ? 7'(CAP) : p;
    endfunction

    assign accept   = start && !busy;
    assign busy     = (r_state == ST_RUN);
    assign last     = (r_idx == IW'(SLOTS - 1));
    assign time_sum = {1'b0, r_now} + 33'(i_item.amount);
    assign time_sat = time_sum[32] ? tsa_pkg::TIME_MAX : time_sum[31:0];

    always_comb begin
        head_ctl.active  = busy;
        head_ctl.func    = r_func;
        head_ctl.grant   = r_grant;
        head_ctl.in_pool = (CW'(r_idx) < CW'(r_pool));
        head_ctl.want    = (r_left != 7'd0);
        head_ctl.name    = r_name;
        head_ctl.tgt     = r_tgt;
    end

    tsa_head u_head (
        .i_slot  (cell_q[0]),
        .i_ctl   (head_ctl),
        .o_slot  (head_next),
        .o_freed (freed),
        .o_taken (taken)
    );

    // Each cell loads its upper neighbor; the top cell takes the processed head record,
    // so after SLOTS shifts every slot is back in its own cell.
    for (genvar j = 0; j < SLOTS; j++) begin : g_cell
        tsa_pkg::t_slot cell_d;
        if (j == SLOTS - 1) begin : g_top
            assign cell_d = head_next;
        end else begin : g_mid
            assign cell_d = cell_q[j + 1];
        end
        tsa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (i_cfg_we),
            .i_shift (busy),
            .i_slot  (cell_d),
            .o_slot  (cell_q[j])
        );
    end

    always_comb begin
        n_state = r_state;
        n_free  = r_free;
        n_freed = r_freed;
        n_left  = r_left;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_RUN;
                    n_freed = '0;
                    n_left  = i_item.request_size;
                    if ((i_item.func == tsa_pkg::FUNC_ADD)
                            && (r_free >= i_item.request_size)) begin
                        n_free = r_free - i_item.request_size;
                    end
                end
            end
            ST_RUN: begin
                if (freed) begin
                    n_free  = r_free + 7'd1;
                    n_freed = r_freed + 7'd1;
                end
                if (taken) begin
                    n_left = r_left - 7'd1;
                end
                if (last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pool   <= tsa_pkg::POOL_RESET;
            r_free   <= pool_limit(tsa_pkg::POOL_RESET);
            r_now    <= '0;
            r_freed  <= '0;
            r_left   <= '0;
            r_idx    <= '0;
            o_strobe <= 1'b0;
        end else if (i_cfg_we) begin
            r_state  <= ST_IDLE;
            r_pool   <= i_cfg_data;
            r_free   <= pool_limit(i_cfg_data);
            r_now    <= '0;
            r_freed  <= '0;
            r_left   <= '0;
            r_idx    <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_free   <= n_free;
            r_freed  <= n_freed;
            r_left   <= n_left;
            o_strobe <= busy && last;
            if (accept && (i_item.func == tsa_pkg::FUNC_PASS)) begin
                r_now <= time_sat;
            end
            if (busy) begin
                r_idx <= last ? '0 : r_idx + IW'(1);
            end
        end
    end

    // Item fields and the result payload carry no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_item.func;
            r_name  <= i_item.proc_name;
            r_tgt   <= time_sat;
            r_grant <= (i_item.func == tsa_pkg::FUNC_PASS)
                    || (r_free >= i_item.request_size);
        end
        if (busy && last) begin
            o_result.accepted    <= r_grant;
            o_result.freed_count <= n_freed;
            o_result.free_count  <= n_free;
        end
    end

endmodule

`default_nettype wire

### test/timed_slot_allocator_unit_test.sv
// Self-checking testbench for timed_slot_allocator_unit: directed lease/expiry cases,
// then random add and pass-time traffic over several pool sizes, checked by a predictor.
// Depends on tsa_pkg and the timed_slot_allocator_unit RTL.
`timescale 1ns / 1ps

module timed_slot_allocator_unit_test;

    localparam int SLOTS       = 64;
    localparam int PHASE_ITEMS = 215;
    localparam int STALL_LIMIT = 2000;

    // Tracks which slots are leased and until when, and queues the result each item must give.
    class slot_lease_tracker;
        bit            held[SLOTS];
        bit [7:0]      owner[SLOTS];
        bit [31:0]     lease_end[SLOTS];
        bit [31:0]     now_ticks;
        int unsigned   free_slots;
        int unsigned   pool_len;
        tsa_pkg::t_out due_results[$];
        int unsigned   mismatches;

        function void set_pool(bit [6:0] size);
            int i;
            pool_len = (size > SLOTS) ? SLOTS : size;
            for (i = 0; i < SLOTS; i++) begin
                held[i]      = 1'b0;
                owner[i]     = tsa_pkg::OWNER_PLACEHOLDER;
                lease_end[i] = '0;
            end
            now_ticks  = '0;
            free_slots = pool_len;
        endfunction

        function bit [31:0] ticks_after(bit [31:0] base, bit [15:0] delta);
            bit [32:0] sum;
            sum = base + delta;
            return sum[32] ? tsa_pkg::TIME_MAX : sum[31:0];
        endfunction

        function void take_item(tsa_pkg::t_in it);
            tsa_pkg::t_out res;
            int unsigned   freed;
            int unsigned   taken;
            bit [31:0]     until_ticks;
            int            i;
            res.accepted = 1'b1;
            freed        = 0;
            if (it.func == tsa_pkg::FUNC_PASS) begin
                now_ticks = ticks_after(now_ticks, it.amount);
                for (i = 0; i < pool_len; i++) begin
                    if (held[i] && lease_end[i] <= now_ticks) begin
                        held[i]  = 1'b0;
                        owner[i] = tsa_pkg::OWNER_PLACEHOLDER;
                        freed++;
                    end
                end
                free_slots += freed;
            end else if (free_slots >= it.request_size) begin
                until_ticks = ticks_after(now_ticks, it.amount);
                taken       = 0;
                for (i = 0; i < pool_len && taken < it.request_size; i++) begin
                    if (!held[i]) begin
                        held[i]      = 1'b1;
                        owner[i]     = it.proc_name;
                        lease_end[i] = until_ticks;
                        taken++;
                    end
                end
                free_slots -= taken;
            end else begin
                res.accepted = 1'b0;
            end
            res.freed_count = 7'(freed);
            res.free_count  = 7'(free_slots);
            due_results.push_back(res);
        endfunction

        function void compare_field(string field, logic [6:0] want, logic [6:0] seen);
            if (seen !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
                mismatches++;
            end
        endfunction

        function void match_result(tsa_pkg::t_out got);
            tsa_pkg::t_out want;
            if (due_results.size() == 0) begin
                $display("%0t: result with none expected, expected none, actual %p", $time, got);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            compare_field("accepted", 7'(want.accepted), 7'(got.accepted));
            compare_field("freed_count", want.freed_count, got.freed_count);
            compare_field("free_count", want.free_count, got.free_count);
        endfunction
    endclass

    logic          i_clk      = 1'b0;
    logic          i_rst_n    = 1'b0;
    logic          i_cfg_we   = 1'b0;
    logic [6:0]    i_cfg_data = '0;
    logic          start      = 1'b0;
    tsa_pkg::t_in  i_item     = '0;
    logic          busy;
    logic          o_strobe;
    tsa_pkg::t_out o_result;

    slot_lease_tracker leases = new();
    int unsigned       sent   = 0;
    int                stall_cycles;
    bit [6:0]          pool_plan[8] = '{7'd8, 7'd1, 7'd0, 7'd127, 7'd65, 7'd64, 7'd0, 7'd37};

    timed_slot_allocator_unit #(
        .SLOTS(SLOTS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .start     (start),
        .i_item    (i_item),
        .busy      (busy),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) leases.take_item(i_item);
            if (o_strobe) leases.match_result(o_result);
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_strobe) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic tsa_pkg::t_in make_item(logic f, logic [7:0] nm, logic [6:0] req,
                                               logic [15:0] amt);
        tsa_pkg::t_in it;
        it.func         = f;
        it.proc_name    = nm;
        it.request_size = req;
        it.amount       = amt;
        return it;
    endfunction

    // Request sizes scale with the pool and lease times roughly match the pass-time steps,
    // so the pool keeps filling, rejecting and draining.
    function automatic tsa_pkg::t_in random_item(int unsigned cap);
        tsa_pkg::t_in it;
        int unsigned  pick;
        it.func      = $urandom_range(0, 1) ? tsa_pkg::FUNC_ADD : tsa_pkg::FUNC_PASS;
        it.proc_name = 8'($urandom_range(0, 255));
        pick         = $urandom_range(0, 9);
        if (pick < 7) it.request_size = 7'($urandom_range(0, cap / 3 + 1));
        else if (pick < 9) it.request_size = 7'($urandom_range(0, cap));
        else it.request_size = 7'($urandom_range(0, 127));
        pick = $urandom_range(0, 9);
        if (pick < 6) it.amount = 16'($urandom_range(0, 40));
        else if (pick < 9) it.amount = 16'($urandom_range(0, 400));
        else it.amount = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    // Returns at the edge where the item is taken; start stays high for a back-to-back transfer.
    task automatic send_item(tsa_pkg::t_in it);
        int unsigned gap;
        bit          after_ready;
        if (sent % 40 < 10) begin
            gap         = 0;
            after_ready = 1'b0;
        end else begin
            gap         = $urandom_range(0, 12);
            after_ready = 1'($urandom_range(0, 1));
        end
        if (gap != 0 || after_ready) begin
            start <= 1'b0;
            if (after_ready) begin
                do @(posedge i_clk); while (busy);
            end
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (leases.due_results.size() != 0 || busy);
    endtask

    task automatic write_pool(bit [6:0] size);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= size;
        leases.set_pool(size);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(int unsigned count);
        int unsigned k;
        for (k = 0; k < count; k++) send_item(random_item(leases.pool_len));
    endtask

    initial begin
        int k;
        leases.set_pool(tsa_pkg::POOL_RESET);
        pool_plan[6] = 7'($urandom_range(2, 63));
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full pool, rejection while full, expiry exactly at the current time, lowest-first reuse.
        send_item(make_item(tsa_pkg::FUNC_PASS, 8'd0, 7'd0, 16'd0));
        send_item(make_item(tsa_pkg::FUNC_ADD, 8'd0, 7'd0, 16'd0));
        send_item(make_item(tsa_pkg::FUNC_ADD, 8'd255, 7'd64, 16'hFFFF));
        send_item(make_item(tsa_pkg::FUNC_ADD, "H", 7'd1, 16'd3));
        send_item(make_item(tsa_pkg::FUNC_ADD, "P", 7'd0, 16'd3));
        send_item(make_item(tsa_pkg::FUNC_PASS, 8'd0, 7'd127, 16'hFFFE));
        send_item(make_item(tsa_pkg::FUNC_PASS, 8'd255, 7'd0, 16'd1));
        send_item(make_item(tsa_pkg::FUNC_ADD, "*", 7'd127, 16'd9));
        send_item(make_item(tsa_pkg::FUNC_ADD, "*", 7'd65, 16'd9));
        send_item(make_item(tsa_pkg::FUNC_ADD, "H", 7'd3, 16'd0));
        send_item(make_item(tsa_pkg::FUNC_ADD, "P", 7'd2, 16'd5));
        send_item(make_item(tsa_pkg::FUNC_PASS, 8'd0, 7'd0, 16'd0));
        send_item(make_item(tsa_pkg::FUNC_ADD, "*", 7'd2, 16'd10));
        send_item(make_item(tsa_pkg::FUNC_PASS, 8'd0, 7'd0, 16'd5));
        send_item(make_item(tsa_pkg::FUNC_PASS, 8'd0, 7'd64, 16'hFFFF));
        send_item(make_item(tsa_pkg::FUNC_ADD, 8'hAA, 7'd64, 16'h5555));
        run_random(PHASE_ITEMS);

        for (k = 0; k < 8; k++) begin
            settle();
            write_pool(pool_plan[k]);
            run_random(PHASE_ITEMS);
        end

        settle();
        repeat (SLOTS + 8) @(posedge i_clk);
        if (leases.mismatches == 0 && leases.due_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### sim.f
sv/tsa_pkg.sv
sv/tsa_cell.sv
sv/tsa_head.sv
sv/timed_slot_allocator_unit.sv
test/timed_slot_allocator_unit_test.sv
